// ----- rtl/text_encoding_detector_top_assert.svh -----
// Assertion macros shared by the RTL files of the text encoding detector.
// Each macro takes a label, the clock, the active-low reset, and the
// expressions that make up the property.
`ifndef TEXT_ENCODING_DETECTOR_TOP_ASSERT_SVH
`define TEXT_ENCODING_DETECTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define TED_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// The expression must never be true.
`define TED_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed");

`else

`define TED_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define TED_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- rtl/ted_pkg.sv -----
package ted_pkg;

	// One input word: a byte of the buffer and its end marker.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	// One verdict word.
	typedef struct packed {
		logic utf8_flag;
		logic ascii_flag;
		logic utf16_be_flag;
		logic utf16_le_flag;
		logic utf32_be_flag;
		logic utf32_le_flag;
	} out_word_t;

	// State of the streaming UTF-8 validator.
	typedef struct packed {
		logic [1:0]  pend;
		logic [2:0]  seq_len;
		logic [20:0] cp;
		logic        broken;
	} utf8_state_t;

	localparam logic [2:0] HeadDepth = 3'd4;

	localparam logic [2:0] SeqLen2 = 3'd2;
	localparam logic [2:0] SeqLen3 = 3'd3;
	localparam logic [2:0] SeqLen4 = 3'd4;

	localparam logic [20:0] Min3Byte = 21'h000800;
	localparam logic [20:0] Min4Byte = 21'h010000;
	localparam logic [20:0] MaxCodepoint = 21'h10FFFF;
	localparam logic [9:0]  SurrogateHigh = 10'h01B;

	// Byte order mark bytes.
	localparam logic [7:0] BomEf = 8'hEF;
	localparam logic [7:0] BomBb = 8'hBB;
	localparam logic [7:0] BomBf = 8'hBF;
	localparam logic [7:0] BomFe = 8'hFE;
	localparam logic [7:0] BomFf = 8'hFF;
	localparam logic [7:0] BomNul = 8'h00;

endpackage

// ----- rtl/ted_in_if.sv -----
interface ted_in_if;
	logic               valid;
	logic               ready;
	ted_pkg::in_word_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/ted_out_if.sv -----
interface ted_out_if;
	logic               valid;
	logic               ready;
	ted_pkg::out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/text_encoding_detector_top.sv -----
// Text encoding detector. Bytes of a buffer arrive on byte_ch, one word per
// byte, with last_byte set on the final byte; one verdict word leaves on
// verdict_ch for each buffer, and nothing for the other bytes. The first four
// bytes are matched against the UTF-8, UTF-16 and UTF-32 byte order marks;
// when a mark is found only its flags are set (a UTF-32 little-endian mark
// also sets the UTF-16 little-endian flag). Without a mark, utf8_flag tells
// whether the whole buffer is valid UTF-8 and ascii_flag whether every byte
// is below 0x80. The block takes one byte per clock cycle unless a last byte
// waits in the stage for the verdict register: each byte passes through an
// input register, one short stage of validator and mark logic, and the
// verdict register, which drives verdict_ch. The verdict register
// holds a finished word while the downstream side stalls, and bytes keep
// flowing into the stage until a second last byte would need that register.
// All buffer state is cleared after each last byte, so buffers may follow
// back to back.
module text_encoding_detector_top (
	input logic          clk,
	input logic          arst_n,
	ted_in_if.sink       byte_ch,
	ted_out_if.source    verdict_ch
);

`include "text_encoding_detector_top_assert.svh"

	// Input register stage.
	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 last_s1;

	// Buffer state.
	logic [7:0]           head_q [4];
	logic [2:0]           seen_q;
	logic                 ascii_bad_q;
	ted_pkg::utf8_state_t utf8_q;

	// Verdict register.
	logic                 verdict_valid_q;
	ted_pkg::out_word_t   verdict_q;

	logic                 adv;
	logic                 take;
	logic [7:0]           head_n [4];
	logic [2:0]           seen_n;
	logic                 ascii_bad_n;
	ted_pkg::utf8_state_t utf8_n;
	logic                 utf8_ok;
	logic                 m8;
	logic                 m16be;
	logic                 m16le;
	logic                 m32be;
	logic                 m32le;
	logic                 any_mark;
	ted_pkg::out_word_t   verdict_n;

	// The stage moves on unless it holds a last byte and the verdict
	// register is still waiting to be taken.
	assign adv = valid_s1 && !(last_s1 && verdict_valid_q && !verdict_ch.ready);
	assign byte_ch.ready = !valid_s1 || adv;
	assign take = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= byte_ch.payload.data_byte;
			last_s1 <= byte_ch.payload.last_byte;
		end
	end

	// The first four bytes are kept for mark matching; the count saturates.
	always_comb begin
		head_n = head_q;
		seen_n = seen_q;
		if (seen_q < ted_pkg::HeadDepth) begin
			head_n[seen_q[1:0]] = data_s1;
			seen_n = seen_q + 3'd1;
		end
	end

	assign ascii_bad_n = ascii_bad_q || data_s1[7];

	ted_utf8_step u_utf8_step (
		.cur        (utf8_q),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.nxt        (utf8_n),
		.valid_utf8 (utf8_ok)
	);

	// Mark matching on the window as it stands after this byte. The UTF-8
	// mark takes priority over all the others.
	always_comb begin
		m8 = (seen_n >= 3'd3) && (head_n[0] == ted_pkg::BomEf) &&
			(head_n[1] == ted_pkg::BomBb) && (head_n[2] == ted_pkg::BomBf);
		m32be = !m8 && (seen_n >= 3'd4) && (head_n[0] == ted_pkg::BomNul) &&
			(head_n[1] == ted_pkg::BomNul) && (head_n[2] == ted_pkg::BomFe) &&
			(head_n[3] == ted_pkg::BomFf);
		m32le = !m8 && (seen_n >= 3'd4) && (head_n[0] == ted_pkg::BomFf) &&
			(head_n[1] == ted_pkg::BomFe) && (head_n[2] == ted_pkg::BomNul) &&
			(head_n[3] == ted_pkg::BomNul);
		m16be = !m8 && (seen_n >= 3'd2) && (head_n[0] == ted_pkg::BomFe) &&
			(head_n[1] == ted_pkg::BomFf);
		m16le = !m8 && (seen_n >= 3'd2) && (head_n[0] == ted_pkg::BomFf) &&
			(head_n[1] == ted_pkg::BomFe);
		any_mark = m8 || m32be || m32le || m16be || m16le;

		verdict_n.utf8_flag = any_mark ? m8 : utf8_ok;
		verdict_n.ascii_flag = !any_mark && !ascii_bad_n;
		verdict_n.utf16_be_flag = m16be;
		verdict_n.utf16_le_flag = m16le;
		verdict_n.utf32_be_flag = m32be;
		verdict_n.utf32_le_flag = m32le;
	end

	// Buffer state is updated for every byte and cleared after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '{default: 8'd0};
			seen_q <= 3'd0;
			ascii_bad_q <= 1'b0;
			utf8_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				head_q <= '{default: 8'd0};
				seen_q <= 3'd0;
				ascii_bad_q <= 1'b0;
				utf8_q <= '0;
			end else begin
				head_q <= head_n;
				seen_q <= seen_n;
				ascii_bad_q <= ascii_bad_n;
				utf8_q <= utf8_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			verdict_valid_q <= 1'b1;
		end else if (verdict_ch.ready) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			verdict_q <= verdict_n;
		end
	end

	assign verdict_ch.valid = verdict_valid_q;
	assign verdict_ch.payload = verdict_q;

	// A new verdict only ever comes from a last byte leaving the stage.
	`TED_ASSERT_IMPLY(a_verdict_from_last, clk, arst_n, verdict_valid_q && !$past(verdict_valid_q), $past(adv && last_s1))
	// The buffer state is empty right after a last byte.
	`TED_ASSERT_NEXT(a_clear_after_last, clk, arst_n, adv && last_s1, (seen_q == 3'd0) && !ascii_bad_q && (utf8_q == '0))
	// A UTF-16 or UTF-32 mark always suppresses the ASCII verdict.
	`TED_ASSERT_IMPLY(a_mark_no_ascii, clk, arst_n, verdict_valid_q && (verdict_q.utf16_be_flag || verdict_q.utf16_le_flag || verdict_q.utf32_be_flag), !verdict_q.ascii_flag)
	// Continuations are only pending inside a multibyte sequence.
	`TED_ASSERT_NEVER(a_pend_needs_seq, clk, arst_n, (utf8_q.pend != 2'd0) && (utf8_q.seq_len == 3'd0))

endmodule

// ----- rtl/ted_utf8_step.sv -----
// Next state of the UTF-8 validator for one byte, and the validity of the
// buffer if that byte ends it.
module ted_utf8_step (
	input  ted_pkg::utf8_state_t cur,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output ted_pkg::utf8_state_t nxt,
	output logic                 valid_utf8
);

	ted_pkg::utf8_state_t fed;
	logic [20:0]          cp_shift;
	logic [1:0]           pend_dec;
	logic                 bad_end;

	assign cp_shift = {cur.cp[14:0], data_byte[5:0]};
	assign pend_dec = cur.pend - 2'd1;

	always_comb begin
		bad_end = 1'b0;
		if (cur.seq_len == ted_pkg::SeqLen3) begin
			bad_end = (cp_shift < ted_pkg::Min3Byte) ||
				(cp_shift[20:11] == ted_pkg::SurrogateHigh);
		end else if (cur.seq_len == ted_pkg::SeqLen4) begin
			bad_end = (cp_shift < ted_pkg::Min4Byte) || (cp_shift > ted_pkg::MaxCodepoint);
		end
	end

	always_comb begin
		fed = cur;
		if (!cur.broken) begin
			if (cur.pend == 2'd0) begin
				if (data_byte inside {[8'h00:8'h7F]}) begin
					fed = cur;
				end else if (data_byte inside {[8'hC2:8'hDF]}) begin
					fed.seq_len = ted_pkg::SeqLen2;
					fed.cp = {16'd0, data_byte[4:0]};
					fed.pend = 2'd1;
				end else if (data_byte inside {[8'hE0:8'hEF]}) begin
					fed.seq_len = ted_pkg::SeqLen3;
					fed.cp = {17'd0, data_byte[3:0]};
					fed.pend = 2'd2;
				end else if (data_byte inside {[8'hF0:8'hF4]}) begin
					fed.seq_len = ted_pkg::SeqLen4;
					fed.cp = {18'd0, data_byte[2:0]};
					fed.pend = 2'd3;
				end else begin
					fed = '0;
					fed.broken = 1'b1;
				end
			end else if (data_byte[7:6] != 2'b10) begin
				fed = '0;
				fed.broken = 1'b1;
			end else if (pend_dec != 2'd0) begin
				fed.cp = cp_shift;
				fed.pend = pend_dec;
			end else if (bad_end) begin
				fed = '0;
				fed.broken = 1'b1;
			end else begin
				fed.pend = 2'd0;
				fed.seq_len = 3'd0;
				fed.cp = '0;
			end
		end
	end

	assign nxt = fed;
	// A sequence still open at the end of the buffer counts as truncated.
	assign valid_utf8 = last_byte && !fed.broken && (fed.pend == 2'd0);

endmodule
